### design/assert_macros.svh
// Assertion macros shared by the thick line rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### design/tlr_pkg.sv
// Types and constants of the thick line rasterizer.
package tlr_pkg;

    localparam int CFG_W    = 13;
    localparam int THICK_W  = 5;
    localparam int ADDR_W   = 24;
    localparam int COLOR_W  = 16;
    localparam int CIDX_W   = 2;

    localparam logic [CFG_W-1:0]   WIDTH_RST  = 13'd320;
    localparam logic [CFG_W-1:0]   HEIGHT_RST = 13'd240;
    localparam logic [CFG_W-1:0]   STRIDE_RST = 13'd320;
    localparam logic [THICK_W-1:0] THICK_RST  = 5'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [CIDX_W-1:0] {
        REG_SCREEN_WIDTH    = 2'd0,
        REG_SCREEN_HEIGHT   = 2'd1,
        REG_ROW_STRIDE      = 2'd2,
        REG_BRUSH_THICKNESS = 2'd3
    } tlr_reg_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic retire;
    } tlr_line_cmd_t;

    typedef struct packed {
        logic active;
        logic at_end;
    } tlr_line_stat_t;

    typedef struct packed {
        logic last;
        logic done;
    } tlr_pix_flags_t;

endpackage

### design/thick_line_rasterizer.sv
// Top level of the thick line rasterizer: configuration, brush sequencer and hookup.
// Load item: no result; the next item is taken on the next cycle.
// Step item: 2*(2*half+1) results if a line is loaded, one per cycle while m_ready is high,
// through the shared clip/address unit; half = min(thickness, MAX_THICK)/2.
// A step's first result passes the state and result registers; output stalls hold the brush walk.
// Synchronous active-low reset: configuration to defaults, no line active, output empty.
`include "assert_macros.svh"

module thick_line_rasterizer
    import tlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int MAX_THICK  = 31
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_write,
    input  logic [CIDX_W-1:0]            cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [COORD_BITS-1:0]        s_x_start,
    input  logic [COORD_BITS-1:0]        s_y_start,
    input  logic [COORD_BITS-1:0]        s_x_end,
    input  logic [COORD_BITS-1:0]        s_y_end,
    input  logic [COLOR_W-1:0]           s_pen_color,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS+1:0] m_pix_x,
    output logic signed [COORD_BITS+1:0] m_pix_y,
    output logic                         m_pix_visible,
    output logic [ADDR_W-1:0]            m_pix_address,
    output logic [COLOR_W-1:0]           m_pix_color,
    output logic                         m_last_of_run,
    output logic                         m_line_done
);

    localparam int PIX_W  = COORD_BITS + 2;
    localparam int K_BITS = $clog2(MAX_THICK + 1);
    localparam logic [THICK_W-1:0] MAX_THICK_W = THICK_W'(MAX_THICK);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t               state_reg;
    logic [K_BITS-1:0]    k_reg, span_reg;
    logic                 vert_reg;

    logic [CFG_W-1:0]     width_reg, height_reg, stride_reg;
    logic [THICK_W-1:0]   thick_reg;

    tlr_line_cmd_t         cmd;
    tlr_line_stat_t        stat;
    tlr_pix_flags_t        flags;
    logic [COORD_BITS-1:0] cur_x, cur_y;
    logic [COLOR_W-1:0]    line_color;

    logic                  accept, start, issue, run_end, pu_ready;
    logic [THICK_W-1:0]    thick_c;
    logic [K_BITS-1:0]     half;
    logic [PIX_W-1:0]      off_x, off_y;
    logic signed [PIX_W-1:0] pix_x, pix_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            stride_reg <= STRIDE_RST;
            thick_reg  <= THICK_RST;
        end else if (cfg_write) begin
            unique case (tlr_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:    width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT:   height_reg <= cfg_data;
                REG_ROW_STRIDE:      stride_reg <= cfg_data;
                REG_BRUSH_THICKNESS: thick_reg  <= cfg_data[THICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        accept  = s_valid && s_ready;
        start   = accept && (s_kind == KIND_STEP) && stat.active;
        thick_c = (thick_reg > MAX_THICK_W) ? MAX_THICK_W : thick_reg;
        half    = span_reg >> 1;
        issue   = (state_reg == ST_RUN) && pu_ready;
        run_end = vert_reg && (k_reg == span_reg);

        off_x = PIX_W'(cur_x) + PIX_W'(k_reg) - PIX_W'(half);
        off_y = PIX_W'(cur_y) + PIX_W'(k_reg) - PIX_W'(half);
        pix_x = vert_reg ? signed'(PIX_W'(cur_x)) : signed'(off_x);
        pix_y = vert_reg ? signed'(off_y) : signed'(PIX_W'(cur_y));

        flags.last = run_end;
        flags.done = run_end && stat.at_end;

        cmd.load    = accept && (s_kind == KIND_LOAD);
        cmd.advance = issue && run_end && !stat.at_end;
        cmd.retire  = issue && run_end && stat.at_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            span_reg  <= '0;
            vert_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_RUN;
                        k_reg     <= '0;
                        vert_reg  <= 1'b0;
                        span_reg  <= K_BITS'(thick_c & ~THICK_W'(1));
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (k_reg == span_reg) begin
                            k_reg <= '0;
                            if (vert_reg) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                vert_reg <= 1'b1;
                            end
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    tlr_line_engine #(
        .COORD_BITS(COORD_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .x_start    (s_x_start),
        .y_start    (s_y_start),
        .x_end      (s_x_end),
        .y_end      (s_y_end),
        .pen_color  (s_pen_color),
        .cur_x      (cur_x),
        .cur_y      (cur_y),
        .line_color (line_color),
        .stat       (stat)
    );

    tlr_pixel_unit #(
        .PIX_W(PIX_W)
    ) u_pixel (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (state_reg == ST_RUN),
        .in_ready      (pu_ready),
        .in_x          (pix_x),
        .in_y          (pix_y),
        .in_color      (line_color),
        .in_flags      (flags),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .row_stride    (stride_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pix_x       (m_pix_x),
        .m_pix_y       (m_pix_y),
        .m_pix_visible (m_pix_visible),
        .m_pix_address (m_pix_address),
        .m_pix_color   (m_pix_color),
        .m_last_of_run (m_last_of_run),
        .m_line_done   (m_line_done)
    );

    `ASSERT_IMPLIES(a_done_on_last, aclk, aresetn, m_valid && m_line_done, m_last_of_run)
    `ASSERT_NEXT(a_retire_clears, aclk, aresetn, cmd.retire, !stat.active)
    `ASSERT_IMPLIES(a_run_needs_line, aclk, aresetn, state_reg == ST_RUN, stat.active)
    `ASSERT_NEXT(a_start_resets_walk, aclk, aresetn, start, (k_reg == '0) && !vert_reg)

endmodule

### design/tlr_line_engine.sv
// Bresenham line state: endpoint load, retire, error update and advance.
module tlr_line_engine
    import tlr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tlr_line_cmd_t         cmd,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic [COLOR_W-1:0]    pen_color,
    output logic [COORD_BITS-1:0] cur_x,
    output logic [COORD_BITS-1:0] cur_y,
    output logic [COLOR_W-1:0]    line_color,
    output tlr_line_stat_t        stat
);

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg, end_x_reg, end_y_reg;
    logic signed [DW-1:0]  delta_x_reg, neg_delta_y_reg;
    logic signed [EW-1:0]  error_reg;
    logic                  step_x_neg_reg, step_y_neg_reg, active_reg;
    logic [COLOR_W-1:0]    color_reg;

    logic signed [DW-1:0]  adx, ady;
    logic signed [EW:0]    e2;
    logic                  move_x, move_y;
    logic signed [EW-1:0]  error_next;

    always_comb begin
        adx = (x_end >= x_start) ? DW'(x_end) - DW'(x_start) : DW'(x_start) - DW'(x_end);
        ady = (y_end >= y_start) ? DW'(y_end) - DW'(y_start) : DW'(y_start) - DW'(y_end);
        e2 = {error_reg, 1'b0};
        move_x = e2 >= (EW + 1)'(neg_delta_y_reg);
        move_y = e2 <= (EW + 1)'(delta_x_reg);
        error_next = error_reg
                   + (move_x ? EW'(neg_delta_y_reg) : '0)
                   + (move_y ? EW'(delta_x_reg) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            delta_x_reg     <= '0;
            neg_delta_y_reg <= '0;
            error_reg       <= '0;
            step_x_neg_reg  <= 1'b0;
            step_y_neg_reg  <= 1'b0;
            color_reg       <= '0;
        end else if (cmd.load) begin
            active_reg      <= 1'b1;
            cur_x_reg       <= x_start;
            cur_y_reg       <= y_start;
            end_x_reg       <= x_end;
            end_y_reg       <= y_end;
            delta_x_reg     <= adx;
            neg_delta_y_reg <= -ady;
            error_reg       <= EW'(adx) - EW'(ady);
            step_x_neg_reg  <= !(x_start < x_end);
            step_y_neg_reg  <= !(y_start < y_end);
            color_reg       <= pen_color;
        end else if (cmd.retire) begin
            active_reg <= 1'b0;
        end else if (cmd.advance) begin
            error_reg <= error_next;
            if (move_x) begin
                cur_x_reg <= step_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (move_y) begin
                cur_y_reg <= step_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
        end
    end

    assign cur_x       = cur_x_reg;
    assign cur_y       = cur_y_reg;
    assign line_color  = color_reg;
    assign stat.active = active_reg;
    assign stat.at_end = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);

endmodule

### design/tlr_pixel_unit.sv
// Shared clip and address unit with the registered result stage.
module tlr_pixel_unit
    import tlr_pkg::*;
#(
    parameter int PIX_W = 14
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [PIX_W-1:0] in_x,
    input  logic signed [PIX_W-1:0] in_y,
    input  logic [COLOR_W-1:0]      in_color,
    input  tlr_pix_flags_t          in_flags,
    input  logic [CFG_W-1:0]        screen_width,
    input  logic [CFG_W-1:0]        screen_height,
    input  logic [CFG_W-1:0]        row_stride,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [PIX_W-1:0] m_pix_x,
    output logic signed [PIX_W-1:0] m_pix_y,
    output logic                    m_pix_visible,
    output logic [ADDR_W-1:0]       m_pix_address,
    output logic [COLOR_W-1:0]      m_pix_color,
    output logic                    m_last_of_run,
    output logic                    m_line_done
);

    localparam int CMP_W  = (PIX_W > CFG_W) ? PIX_W : CFG_W;
    localparam int PROD_W = PIX_W + CFG_W;
    localparam int SUM_W  = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

    logic                    valid_reg;
    logic signed [PIX_W-1:0] x_reg, y_reg;
    logic                    vis_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [COLOR_W-1:0]      color_reg;
    tlr_pix_flags_t          flags_reg;

    logic                    take;
    logic                    vis;
    logic [PROD_W-1:0]       prod;
    logic [SUM_W-1:0]        sum;

    always_comb begin
        take = in_valid && in_ready;
        vis  = !in_x[PIX_W-1] && !in_y[PIX_W-1]
            && (CMP_W'(unsigned'(in_x)) < CMP_W'(screen_width))
            && (CMP_W'(unsigned'(in_y)) < CMP_W'(screen_height));
        prod = PROD_W'(unsigned'(in_y)) * PROD_W'(row_stride);
        sum  = SUM_W'(prod) + SUM_W'(unsigned'(in_x));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg     <= in_x;
            y_reg     <= in_y;
            vis_reg   <= vis;
            addr_reg  <= vis ? sum[ADDR_W-1:0] : '0;
            color_reg <= in_color;
            flags_reg <= in_flags;
        end
    end

    assign in_ready      = !valid_reg || m_ready;
    assign m_valid       = valid_reg;
    assign m_pix_x       = x_reg;
    assign m_pix_y       = y_reg;
    assign m_pix_visible = vis_reg;
    assign m_pix_address = addr_reg;
    assign m_pix_color   = color_reg;
    assign m_last_of_run = flags_reg.last;
    assign m_line_done   = flags_reg.done;

endmodule
